FILE: design/pfl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_pkg: shared types and constants for the pool free list allocator
// Holds opcodes, register indexes, field widths and the decision record
// that goes from the allocation stage to the address stage.
// ---------------------------------------------------------------------------
package pfl_pkg;

    localparam int OP_W       = 2;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = COUNT_W + SIZE_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE  = 2'd2;

    // reset values
    localparam logic [ADDR_W-1:0]  RESET_BASE  = 32'd0;
    localparam logic [COUNT_W-1:0] RESET_COUNT = 11'd1024;
    localparam logic [SIZE_W-1:0]  RESET_SIZE  = 16'd4;

    // outcome of one request, before the address is formed
    typedef struct packed {
        logic               valid;
        logic               ok;
        logic               addr_en;
        logic [COUNT_W-1:0] idx;
    } pfl_decision_t;

endpackage

FILE: design/pfl_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_ram: generic single-write, single-read memory
// One write port and one read port with a read enable; read data is
// registered and holds while no read is issued.
// ---------------------------------------------------------------------------
module pfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pfl_addr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_addr: element address stage
// Forms base plus index times size for a decided request and registers
// the finished result beat with its strobe.
// ---------------------------------------------------------------------------
module pfl_addr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfl_pkg::pfl_decision_t        decision,
    input  logic [pfl_pkg::ADDR_W-1:0]    pool_base,
    input  logic [pfl_pkg::SIZE_W-1:0]    element_size,
    output logic                          done,
    output logic                          ok,
    output logic [pfl_pkg::INDEX_W-1:0]   element_index,
    output logic [pfl_pkg::ADDR_W-1:0]    element_address
);

    import pfl_pkg::*;

    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  addr_sum;
    logic               done_reg;
    logic               ok_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [ADDR_W-1:0]  address_reg;

    // index times size never exceeds 27 bits
    assign prod     = PROD_W'(decision.idx) * PROD_W'(element_size);
    assign addr_sum = pool_base + {{(ADDR_W - PROD_W){1'b0}}, prod};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= decision.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg      <= decision.ok;
        index_reg   <= decision.idx[INDEX_W-1:0];
        address_reg <= decision.addr_en ? addr_sum : '0;
    end

    assign done            = done_reg;
    assign ok              = ok_reg;
    assign element_index   = index_reg;
    assign element_address = address_reg;

endmodule

FILE: design/pool_free_list_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pool_free_list_allocator: fixed-size element pool allocator
// Hands out and takes back element indexes of a pool through a LIFO free
// list backed by a link memory, with a watermark for never-used elements.
// ---------------------------------------------------------------------------
// usage
//   request channel: start with opcode (alloc, free, clear) and free_index;
//   a beat is taken at each edge with start high and busy low. busy never
//   rises, so one request can enter every cycle
//   result channel: done strobes for one cycle with ok, element_index and
//   element_address; every request yields exactly one result beat
//   pipeline: a request passes the input register, decision_reg and the
//   address stage result registers; throughput is one request per cycle, set by
//   the single link memory port pair and the prefetched successor of head
//   config port: cfg_we, cfg_index, cfg_data; write only while idle
//   reset: registers go to base 0, count 1024, size 4; the free list is
//   empty and the watermark is zero. the link memory is not cleared and
//   needs no clearing pass, it only holds entries written by free
//   stalls: the receiver cannot hold results off, so no output queue exists
// ---------------------------------------------------------------------------
module pool_free_list_allocator #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic [pfl_pkg::OP_W-1:0]          opcode,
    input  logic [pfl_pkg::INDEX_W-1:0]       free_index,
    // result channel
    output logic                              done,
    output logic                              ok,
    output logic [pfl_pkg::INDEX_W-1:0]       element_index,
    output logic [pfl_pkg::ADDR_W-1:0]        element_address,
    // config write port
    input  logic                              cfg_we,
    input  logic [pfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import pfl_pkg::*;

    // link memory is only ever written at freed indexes, which are below 1024
    localparam int LINK_DEPTH = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    // largest usable count, clipped to what the count register can hold
    localparam logic [COUNT_W-1:0] MAX_CAP =
        (MAX_ELEMENTS > 2047) ? 11'd2047 : MAX_ELEMENTS[COUNT_W-1:0];

    // config registers
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [COUNT_W-1:0] element_count_reg;
    logic [SIZE_W-1:0]  element_size_reg;

    // input register
    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    logic [INDEX_W-1:0] fidx_reg;

    // allocator state
    logic [COUNT_W-1:0] head_reg, head_next;
    logic [COUNT_W-1:0] mark_reg, mark_next;
    // successor of head: held here after a free, in the memory read
    // register after a pop
    logic [COUNT_W-1:0] head_link_reg, head_link_next;
    logic               link_sel_reg, link_sel_next;

    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] fidx_ext;
    logic [COUNT_W-1:0] link_cur;
    logic [COUNT_W-1:0] ram_rdata;
    logic               ram_we;
    logic               ram_re;

    pfl_decision_t      decision;
    pfl_decision_t      decision_reg;

    // always ready for another beat
    assign busy = 1'b0;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg     <= RESET_BASE;
            element_count_reg <= RESET_COUNT;
            element_size_reg  <= RESET_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:     pool_base_reg     <= cfg_data[ADDR_W-1:0];
                CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_ELEMENT_SIZE:  element_size_reg  <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // capture request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= opcode;
        fidx_reg <= free_index;
    end

    assign cnt      = (element_count_reg > MAX_CAP) ? MAX_CAP : element_count_reg;
    assign fidx_ext = {1'b0, fidx_reg};
    assign link_cur = link_sel_reg ? ram_rdata : head_link_reg;

    // allocation decision for the registered request
    always_comb
    begin
        head_next      = head_reg;
        mark_next      = mark_reg;
        head_link_next = head_link_reg;
        link_sel_next  = link_sel_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        decision       = '0;
        decision.valid = in_valid_reg;
        if (in_valid_reg)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (head_reg < cnt)
                    begin
                        // pop: fetch the successor of the new head now
                        decision.ok      = 1'b1;
                        decision.addr_en = 1'b1;
                        decision.idx     = head_reg;
                        head_next        = link_cur;
                        ram_re           = 1'b1;
                        link_sel_next    = 1'b1;
                    end
                    else if (mark_reg < cnt)
                    begin
                        decision.ok      = 1'b1;
                        decision.addr_en = 1'b1;
                        decision.idx     = mark_reg;
                        mark_next        = mark_reg + 11'd1;
                    end
                end
                OP_FREE:
                begin
                    decision.idx = fidx_ext;
                    if (fidx_ext < cnt)
                    begin
                        // push: old head becomes the link of the freed element
                        decision.ok      = 1'b1;
                        decision.addr_en = 1'b1;
                        ram_we           = 1'b1;
                        head_next        = fidx_ext;
                        head_link_next   = head_reg;
                        link_sel_next    = 1'b0;
                    end
                end
                OP_CLEAR:
                begin
                    decision.ok   = 1'b1;
                    head_next     = cnt;
                    mark_next     = '0;
                    link_sel_next = 1'b0;
                end
                default:
                begin
                    decision.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= RESET_COUNT;
            mark_reg     <= '0;
            link_sel_reg <= 1'b0;
            decision_reg <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            mark_reg     <= mark_next;
            link_sel_reg <= link_sel_next;
            decision_reg <= decision;
        end
    end

    always_ff @(posedge clk)
    begin
        head_link_reg <= head_link_next;
    end

    // link memory: successor of each freed element
    pfl_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fidx_reg[LINK_AW-1:0]),
        .wdata (head_reg),
        .re    (ram_re),
        .raddr (link_cur[LINK_AW-1:0]),
        .rdata (ram_rdata)
    );

    // address and result register
    pfl_addr u_addr (
        .clk             (clk),
        .rst_n           (rst_n),
        .decision        (decision_reg),
        .pool_base       (pool_base_reg),
        .element_size    (element_size_reg),
        .done            (done),
        .ok              (ok),
        .element_index   (element_index),
        .element_address (element_address)
    );

endmodule

FILE: tb/pool_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pool_free_list_allocator_tb: self-checking bench for the pool allocator
// Drives alloc, free, clear and unused-opcode requests under several pool
// settings, predicts every result beat from a private model of the free
// list, link store and watermark, and compares each beat field by field.
// ---------------------------------------------------------------------------
module pool_free_list_allocator_tb;

    import pfl_pkg::*;

    // the one opcode the package leaves unnamed
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_DEPTH = 1024;
    // cycles with no beat in either direction before the run is abandoned
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES = 12;
    localparam int BEATS_PER_PHASE = 160;

    typedef struct {
        logic               ok;
        logic [INDEX_W-1:0] idx;
        logic [ADDR_W-1:0]  addr;
    } pool_result_t;

    // -----------------------------------------------------------------------
    // scoreboard: private copy of the allocator state plus expected beats
    // -----------------------------------------------------------------------
    class pool_scoreboard;
        logic [ADDR_W-1:0]  base;
        logic [COUNT_W-1:0] count;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] head;
        logic [COUNT_W-1:0] mark;
        logic [COUNT_W-1:0] link [POOL_DEPTH];
        bit                 link_set [POOL_DEPTH];
        logic [INDEX_W-1:0] handed_out [$];
        pool_result_t       awaited_results [$];
        int mismatches, requests, results, grants, refusals, frees, clears;

        function new();
            base  = RESET_BASE;
            count = RESET_COUNT;
            size  = RESET_SIZE;
            head  = RESET_COUNT;
            mark  = '0;
            foreach (link_set[i])
            begin
                link_set[i] = 1'b0;
                link[i] = '0;
            end
        endfunction

        function logic [COUNT_W-1:0] live_count();
            return (count > POOL_DEPTH) ? COUNT_W'(POOL_DEPTH) : count;
        endfunction

        function logic [ADDR_W-1:0] byte_address(logic [COUNT_W-1:0] i);
            return base + 32'(i) * 32'(size);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_POOL_BASE:     base  = data;
                CFG_ELEMENT_COUNT: count = data[COUNT_W-1:0];
                CFG_ELEMENT_SIZE:  size  = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // an alloc now would pop through a link entry that no free has written
        function bit pop_blind();
            return (head < live_count()) && !link_set[head[INDEX_W-1:0]];
        endfunction

        // an index handed out earlier, so most frees give back live elements
        function logic [INDEX_W-1:0] take_held();
            int pos;
            logic [INDEX_W-1:0] i;
            if (handed_out.size() == 0)
                return INDEX_W'($urandom_range(0, POOL_DEPTH - 1));
            pos = $urandom_range(0, handed_out.size() - 1);
            i = handed_out[pos];
            handed_out.delete(pos);
            return i;
        endfunction

        // next state and result beat for one accepted request
        function pool_result_t allocate_or_release(logic [OP_W-1:0] op,
                                                   logic [INDEX_W-1:0] fidx);
            pool_result_t r;
            logic [COUNT_W-1:0] cnt;
            logic [COUNT_W-1:0] i;
            cnt = live_count();
            r.ok = 1'b0;
            r.idx = '0;
            r.addr = '0;
            case (op)
                OP_ALLOC:
                begin
                    i = '0;
                    if (head < cnt)
                    begin
                        // pop the most recently freed element
                        i = head;
                        head = link[i[INDEX_W-1:0]];
                        r.ok = 1'b1;
                    end
                    else if (mark < cnt)
                    begin
                        // list empty, take the next never-used element
                        i = mark;
                        mark = mark + 1'b1;
                        r.ok = 1'b1;
                    end
                    if (r.ok)
                    begin
                        r.idx = i[INDEX_W-1:0];
                        r.addr = byte_address(i);
                        handed_out.push_back(r.idx);
                        grants++;
                    end
                    else
                        refusals++;
                end
                OP_FREE:
                begin
                    r.idx = fidx;
                    if (COUNT_W'(fidx) < cnt)
                    begin
                        link[fidx] = head;
                        link_set[fidx] = 1'b1;
                        head = COUNT_W'(fidx);
                        r.ok = 1'b1;
                        r.addr = byte_address(COUNT_W'(fidx));
                        frees++;
                    end
                end
                OP_CLEAR:
                begin
                    head = cnt;
                    mark = '0;
                    r.ok = 1'b1;
                    handed_out.delete();
                    clears++;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] fidx);
            requests++;
            awaited_results.push_back(allocate_or_release(op, fidx));
        endfunction

        function void check_result(logic ok_a, logic [INDEX_W-1:0] idx_a,
                                   logic [ADDR_W-1:0] addr_a);
            pool_result_t e;
            results++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: ok=%0b idx=%0d addr=%h",
                             $realtime, ok_a, idx_a, addr_a);
                return;
            end
            e = awaited_results.pop_front();
            if (ok_a !== e.ok || idx_a !== e.idx || addr_a !== e.addr)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected ok=%0b idx=%0d addr=%h, got ok=%0b idx=%0d addr=%h",
                             $realtime, e.ok, e.idx, e.addr, ok_a, idx_a, addr_a);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // signals and the block
    // -----------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       opcode;
    logic [INDEX_W-1:0]    free_index;
    logic                  done;
    logic                  ok;
    logic [INDEX_W-1:0]    element_index;
    logic [ADDR_W-1:0]     element_address;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pool_scoreboard sb;
    int quiet_cycles;
    int settings_used;

    pool_free_list_allocator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .free_index      (free_index),
        .done            (done),
        .ok              (ok),
        .element_index   (element_index),
        .element_address (element_address),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, inputs only move at
    // the falling edge, so request, result and register beats never race
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // note the request first; its own result can never share this edge
            if (start && !busy)
                sb.note_request(opcode, free_index);
            if (done)
                sb.check_result(ok, element_index, element_address);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if ((start && !busy) || done || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: nothing moved for too long
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one request beat; choices that depend on the predicted state are made
    // at the falling edge, after the previous beat has been noted
    task automatic issue(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                         input bit from_held, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            // idle with junk on the payload
            start = 1'b0;
            opcode = OP_W'($urandom);
            free_index = INDEX_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        if (from_held)
            idx = sb.take_held();
        // never let a pop walk into a link entry that was never written
        if (op == OP_ALLOC && sb.pop_blind())
            op = OP_CLEAR;
        start = 1'b1;
        opcode = op;
        free_index = idx;
        do @(posedge clk); while (busy);
    endtask

    // drop start and wait until every expected beat is back, plus the pipe
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_data = CFG_DATA_W'($urandom);
    endtask

    // new pool setting, only ever applied with the block idle
    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] cnt,
                            input logic [SIZE_W-1:0] sz);
        drain();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_ELEMENT_COUNT, CFG_DATA_W'(cnt));
        write_reg(CFG_ELEMENT_SIZE, CFG_DATA_W'(sz));
        settings_used++;
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        logic [ADDR_W-1:0]  p_base;
        logic [COUNT_W-1:0] p_count;
        logic [SIZE_W-1:0]  p_size;
        bit                 no_gaps;
        int                 r;

        sb = new();
        quiet_cycles = 0;
        settings_used = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ALLOC;
        free_index = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_POOL_BASE;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: watermark allocs, pushes and pops, top index,
        // unused opcode, clear and a fresh start from element zero
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_FREE, 10'd1, 1'b0, 0);
        issue(OP_FREE, 10'd1023, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 1);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_UNUSED, 10'd1023, 1'b0, 0);
        issue(OP_FREE, 10'd0, 1'b0, 2);
        issue(OP_CLEAR, 10'd1023, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_FREE, 10'd1023, 1'b0, 0);

        // two-element pool near the top of memory: address wrap,
        // exhaustion and a free beyond the element count
        set_pool(32'hFFFF_FFF0, 11'd2, 16'hFFFF);
        issue(OP_CLEAR, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_FREE, 10'd2, 1'b0, 0);
        issue(OP_FREE, 10'd1, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);
        issue(OP_CLEAR, 10'd0, 1'b0, 0);
        issue(OP_ALLOC, 10'd0, 1'b0, 0);

        // random phases, extremes first, then mostly small pools so that
        // exhaustion and list reuse come up often
        for (int p = 0; p < PHASES; p++)
        begin
            p_base = ADDR_W'($urandom);
            case (p)
                0: begin p_base = 32'hFFFF_FFFF; p_count = 11'd1024; p_size = 16'hFFFF; end
                1: begin p_count = 11'd1; p_size = 16'd4; end
                2: begin p_base = '0; p_count = 11'd0; p_size = 16'd0; end
                3: begin p_count = 11'd2047; p_size = 16'd1; end
                4: begin p_count = 11'd3; p_size = 16'hFFFF; end
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        p_count = COUNT_W'($urandom_range(1, 1024));
                    else
                        p_count = COUNT_W'($urandom_range(1, 48));
                    p_size = SIZE_W'($urandom);
                end
            endcase
            set_pool(p_base, p_count, p_size);
            // some phases keep the old list and watermark across the change
            if (p % 3 != 2)
                issue(OP_CLEAR, INDEX_W'($urandom), 1'b0, 0);
            no_gaps = (p % 4 == 1);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    issue(OP_ALLOC, INDEX_W'($urandom), 1'b0, no_gaps ? 0 : pick_gap());
                else if (r < 75)
                    issue(OP_FREE, '0, 1'b1, no_gaps ? 0 : pick_gap());
                else if (r < 87)
                    issue(OP_FREE, INDEX_W'($urandom), 1'b0, no_gaps ? 0 : pick_gap());
                else if (r < 93)
                    issue(OP_CLEAR, INDEX_W'($urandom), 1'b0, no_gaps ? 0 : pick_gap());
                else
                    issue(OP_UNUSED, INDEX_W'($urandom), 1'b0, no_gaps ? 0 : pick_gap());
            end
        end

        drain();
        repeat (6) @(posedge clk);

        $display("covered %0d requests and %0d result beats over %0d pool settings",
                 sb.requests, sb.results, settings_used);
        $display("allocs granted %0d, refused %0d; frees taken %0d; clears %0d; mismatches %0d",
                 sb.grants, sb.refusals, sb.frees, sb.clears, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
